FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the window peak tracker checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define WPT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define WPT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/wpt_pkg.sv
// ---------------------------------------------------------------------------
// Window peak tracker package
// Types and constants shared by the tracker's modules.
// ---------------------------------------------------------------------------
package wpt_pkg;

   localparam int SampleWidth = 31;
   localparam int TroughWidth = 32;
   localparam int CountWidth  = 16;

   // Trough value that means no trough has been seen yet.
   localparam logic [TroughWidth-1:0] TroughNone = '1;
   // Saturation value of the peak count.
   localparam logic [CountWidth-1:0]  CountMax   = '1;

   typedef struct packed {
      logic                   slow_start;
      logic [SampleWidth-1:0] prev_sample;
      logic                   falling;
      logic [SampleWidth-1:0] highest_peak;
      logic [TroughWidth-1:0] lowest_trough;
      logic [CountWidth-1:0]  peak_total;
   } state_type;

   typedef struct packed {
      logic [SampleWidth-1:0] peak_max;
      logic [TroughWidth-1:0] trough_min;
      logic [CountWidth-1:0]  peak_count;
      logic                   in_slow_start;
   } result_type;

   // Tracker state right after reset.
   localparam state_type StateReset = '{
      slow_start:    1'b1,
      prev_sample:   '0,
      falling:       1'b0,
      highest_peak:  '0,
      lowest_trough: TroughNone,
      peak_total:    '0
   };

endpackage

FILE: src/window_peak_tracker_core.sv
// ---------------------------------------------------------------------------
// Window peak tracker core
// Follows the trend of congestion-window samples: slow start, peaks, troughs.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_ready  window_sample (31 b unsigned)
//   rsp_     out        rsp_valid/rsp_ready  peak_max, trough_min, peak_count,
//                                            in_slow_start
//
// One sample is taken in every cycle while the result register can load.
// Each transfer on the request side produces exactly one result, visible in
// the result register in the cycle after the transfer. The rate is set by
// the one combinational state update between the tracker and result registers.
// Reset is synchronous and active high; it returns the tracker to slow start.
// When the result register is full and not taken, req_ready drops and the
// tracker state holds until the result is transferred.
// ---------------------------------------------------------------------------
module window_peak_tracker_core
   import wpt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [SampleWidth-1:0]        req_window_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SampleWidth-1:0]        rsp_peak_max,
   output logic signed [TroughWidth-1:0] rsp_trough_min,
   output logic [CountWidth-1:0]         rsp_peak_count,
   output logic                          rsp_in_slow_start
);

   // Tracker state: the previous sample, the trend flags and the statistics.
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type rsp_data;
   logic       req_xfer;
   logic       can_load;

   // A request transfer happens when req_valid is high and the result register can load.
   assign req_ready = can_load;
   assign req_xfer  = req_valid && req_ready;

   wpt_step u_step (
      .cur_state  (state_ff),
      .sample     (req_window_sample),
      .next_state (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // The result shows the state after this sample's update.
   always_comb begin
      result_in.peak_max      = state_in.highest_peak;
      result_in.trough_min    = state_in.lowest_trough;
      result_in.peak_count    = state_in.peak_total;
      result_in.in_slow_start = state_in.slow_start;
   end

   wpt_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_xfer),
      .load_data (result_in),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_peak_max      = rsp_data.peak_max;
   assign rsp_trough_min    = $signed(rsp_data.trough_min);
   assign rsp_peak_count    = rsp_data.peak_count;
   assign rsp_in_slow_start = rsp_data.in_slow_start;

endmodule

FILE: src/wpt_step.sv
// ---------------------------------------------------------------------------
// Window peak tracker update
// Next tracker state for one window sample.
// ---------------------------------------------------------------------------
module wpt_step
   import wpt_pkg::*;
(
   input  state_type              cur_state,
   input  logic [SampleWidth-1:0] sample,
   output state_type              next_state
);

   logic is_drop;
   logic is_rise;
   logic trough_lower;

   assign is_drop = sample < cur_state.prev_sample;
   assign is_rise = sample > cur_state.prev_sample;
   // An empty trough (all ones) is above every 31-bit sample, but keep it explicit.
   assign trough_lower = (cur_state.lowest_trough == TroughNone) ||
                         ({1'b0, cur_state.prev_sample} < cur_state.lowest_trough);

   always_comb begin
      next_state = cur_state;
      if (cur_state.slow_start) begin
         if (is_drop) begin
            next_state.slow_start   = 1'b0;
            next_state.highest_peak = cur_state.prev_sample;
            next_state.peak_total   = CountWidth'(1);
            next_state.falling      = 1'b1;
         end
      end else if (is_drop) begin
         if (cur_state.prev_sample > cur_state.highest_peak) begin
            next_state.highest_peak = cur_state.prev_sample;
         end
         if (!cur_state.falling && (cur_state.peak_total != CountMax)) begin
            next_state.peak_total = cur_state.peak_total + CountWidth'(1);
         end
         next_state.falling = 1'b1;
      end else if (is_rise) begin
         if (trough_lower) begin
            next_state.lowest_trough = {1'b0, cur_state.prev_sample};
         end
         next_state.falling = 1'b0;
      end
      next_state.prev_sample = sample;
   end

endmodule

FILE: src/wpt_rsp_reg.sv
// ---------------------------------------------------------------------------
// Window peak tracker result register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module wpt_rsp_reg
   import wpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       can_load,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // The register may be refilled in the same cycle its content is taken.
   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: src/wpt_checker.sv
// ---------------------------------------------------------------------------
// Window peak tracker checker
// Port-level assertions on the tracker core, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wpt_checker
   import wpt_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [SampleWidth-1:0]        rsp_peak_max,
   input logic signed [TroughWidth-1:0] rsp_trough_min,
   input logic [CountWidth-1:0]         rsp_peak_count,
   input logic                          rsp_in_slow_start
);

   logic count_matches;
   logic stats_empty;

   assign count_matches = rsp_in_slow_start == (rsp_peak_count == '0);
   assign stats_empty   = (rsp_peak_max == '0) && (rsp_trough_min == -32'sd1);

   // No result may be pending right after reset.
   `WPT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // A result stays offered until it is transferred.
   `WPT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")

   // Every request transfer leaves a result in the register.
   `WPT_ASSERT(a_req_rsp, clock, reset, req_valid && req_ready |=> rsp_valid, "result missing")

   // The peak count is zero exactly while slow start lasts.
   `WPT_ASSERT(a_count_slow_start, clock, reset, rsp_valid |-> count_matches, "count vs slow start")

   // During slow start there is neither a peak nor a trough.
   `WPT_ASSERT(a_slow_start_empty, clock, reset, rsp_valid && rsp_in_slow_start |-> stats_empty, "stats set")

endmodule

bind window_peak_tracker_core wpt_checker u_wpt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_peak_max      (rsp_peak_max),
   .rsp_trough_min    (rsp_trough_min),
   .rsp_peak_count    (rsp_peak_count),
   .rsp_in_slow_start (rsp_in_slow_start)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Window peak tracker testbench
// Streams congestion-window samples into the tracker core. Samples come from
// a short hand-picked opening, a random trend walk inside a band that widens
// over the run, a burst of extreme values, and a short sweep of rise/drop
// pairs. Every result is checked field by field against a behavioral copy of
// the tracker, while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
   import wpt_pkg::*;

   localparam logic [SampleWidth-1:0] SampleMax   = '1;
   localparam int                     RandomItems = 1080;
   // Rise/drop pairs in the closing sweep.
   localparam int                     SweepPairs  = 20;
   localparam int                     DrainCycles = 10;
   localparam int                     MaxPrinted  = 20;

   logic                          clock             = 1'b0;
   logic                          reset             = 1'b1;
   logic                          req_valid         = 1'b0;
   logic                          req_ready;
   logic [SampleWidth-1:0]        req_window_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready         = 1'b0;
   logic [SampleWidth-1:0]        rsp_peak_max;
   logic signed [TroughWidth-1:0] rsp_trough_min;
   logic [CountWidth-1:0]         rsp_peak_count;
   logic                          rsp_in_slow_start;

   // Samples waiting to be sent, and the tracker outputs predicted for the
   // samples that have already been transferred.
   logic [SampleWidth-1:0] window_samples[$];
   result_type             predicted_stats[$];
   state_type              trend = StateReset;

   int total_samples    = 0;
   int samples_sent     = 0;
   int results_checked  = 0;
   int saturated_seen   = 0;
   int error_count      = 0;
   int send_gap         = 0;
   int send_calm        = 0;
   int stall_left       = 0;
   int recv_calm        = 0;

   window_peak_tracker_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_window_sample (req_window_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_peak_max      (rsp_peak_max),
      .rsp_trough_min    (rsp_trough_min),
      .rsp_peak_count    (rsp_peak_count),
      .rsp_in_slow_start (rsp_in_slow_start)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #150_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MaxPrinted) begin
         $display("ERROR: %s", msg);
      end
   endtask

   // Idle length for either channel: mostly none, some short, a few long, and
   // now and then a calm stretch with no idling at all.
   function automatic int pick_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm_left = $urandom_range(30, 200);
         return 0;
      end
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 16);
   endfunction

   // Applies one sample to the tracker copy and returns the outputs that the
   // block must show afterwards.
   function automatic result_type update_trend(input logic [SampleWidth-1:0] sample);
      logic [SampleWidth-1:0] last;
      result_type             stats;
      last = trend.prev_sample;
      if (trend.slow_start) begin
         // Slow start only ends at the first drop; rises leave the trough alone.
         if (sample < last) begin
            trend.slow_start   = 1'b0;
            trend.highest_peak = last;
            trend.peak_total   = CountWidth'(1);
            trend.falling      = 1'b1;
         end
      end else if (sample < last) begin
         if (last > trend.highest_peak) trend.highest_peak = last;
         if (!trend.falling && trend.peak_total != CountMax) begin
            trend.peak_total = trend.peak_total + 1'b1;
         end
         trend.falling = 1'b1;
      end else if (sample > last) begin
         if (trend.lowest_trough == TroughNone || {1'b0, last} < trend.lowest_trough) begin
            trend.lowest_trough = {1'b0, last};
         end
         trend.falling = 1'b0;
      end
      trend.prev_sample   = sample;
      stats.peak_max      = trend.highest_peak;
      stats.trough_min    = trend.lowest_trough;
      stats.peak_count    = trend.peak_total;
      stats.in_slow_start = trend.slow_start;
      return stats;
   endfunction

   // Request driver: predicts on every transfer, then idles or presents the
   // next sample. Each output gets exactly one assignment per edge.
   always @(posedge clock) begin : sample_driver
      logic                   next_valid;
      logic [SampleWidth-1:0] next_sample;
      next_valid  = req_valid;
      next_sample = req_window_sample;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_stats.push_back(update_trend(req_window_sample));
            samples_sent++;
            next_valid = 1'b0;
            send_gap   = pick_gap(send_calm);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (window_samples.size() > 0) begin
               next_valid  = 1'b1;
               next_sample = window_samples.pop_front();
            end
         end
      end
      req_valid         <= next_valid;
      req_window_sample <= next_sample;
   end

   // Result monitor: checks each transfer against the oldest prediction and
   // throttles rsp_ready, sometimes even while no result is pending.
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_stats.size() == 0) begin
               report_error($sformatf("result transfer with no sample pending: peak_count %0d",
                                      rsp_peak_count));
            end else begin
               want = predicted_stats.pop_front();
               if (rsp_peak_max !== want.peak_max) begin
                  report_error($sformatf("result %0d peak_max: got 0x%0h, expected 0x%0h",
                                         results_checked, rsp_peak_max, want.peak_max));
               end
               if (rsp_trough_min !== want.trough_min) begin
                  report_error($sformatf("result %0d trough_min: got 0x%0h, expected 0x%0h",
                                         results_checked, rsp_trough_min, want.trough_min));
               end
               if (rsp_peak_count !== want.peak_count) begin
                  report_error($sformatf("result %0d peak_count: got %0d, expected %0d",
                                         results_checked, rsp_peak_count, want.peak_count));
               end
               if (rsp_in_slow_start !== want.in_slow_start) begin
                  report_error($sformatf("result %0d in_slow_start: got %b, expected %b",
                                         results_checked, rsp_in_slow_start,
                                         want.in_slow_start));
               end
            end
            if (rsp_peak_count === CountMax) saturated_seen++;
            results_checked++;
            stall_left = pick_gap(recv_calm);
         end else if (!rsp_valid && stall_left == 0 && $urandom_range(0, 19) == 0) begin
            stall_left = pick_gap(recv_calm);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [SampleWidth-1:0] opening_run [17];
      logic [SampleWidth-1:0] extreme_run [8];
      logic [SampleWidth-1:0] last_sample;
      longint                 band_lo;
      longint                 band_hi;
      longint                 value;
      longint                 step;
      int                     trend_dir;
      int                     trend_left;
      int                     pick;

      // Opening run: equal and rising samples inside slow start, the drop that
      // ends it, a second drop while falling, trough set from none, new peaks,
      // and repeated values on both trends.
      opening_run = '{
         31'd0, 31'd1000, 31'd1000, 31'd5000, 31'd4000, 31'd3000, 31'd3000,
         31'd3500, 31'd3500, 31'd6000, 31'd2000, 31'd2500, 31'd2400, 31'd2400,
         31'd2300, 31'd7000, 31'd6999
      };
      // Extremes of the sample field: a rise from zero and a drop from the top.
      extreme_run = '{
         31'd0, 31'd0, SampleMax, SampleMax, 31'd0, SampleMax - 1'b1, SampleMax, 31'd1
      };

      foreach (opening_run[i]) window_samples.push_back(opening_run[i]);
      last_sample = opening_run[16];

      // Random trend walk. The band starts narrow and widens, so the peak and
      // trough statistics keep moving through the whole phase instead of
      // pinning at the field limits early.
      trend_dir  = 1;
      trend_left = 0;
      for (int k = 0; k < RandomItems; k++) begin
         if (k >= RandomItems * 9 / 10) begin
            band_lo = 1;
            band_hi = longint'(SampleMax) - 1;
         end else begin
            band_hi = longint'(8000) << (k * 18 / RandomItems);
            band_lo = longint'(2000) >> (k * 11 / RandomItems);
            if (band_lo < 1) band_lo = 1;
            if (band_hi > longint'(SampleMax) - 1) band_hi = longint'(SampleMax) - 1;
         end
         if (trend_left == 0) begin
            trend_dir  = $urandom_range(0, 1) ? 1 : -1;
            trend_left = $urandom_range(1, 8);
         end
         trend_left--;
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            value = longint'(last_sample);
         end else if (pick < 27) begin
            value = band_lo + longint'($urandom()) % (band_hi - band_lo + 1);
         end else begin
            if (pick < 45) step = longint'($urandom_range(1, 4));
            else step = 1 + longint'($urandom()) % ((band_hi - band_lo) / 4 + 1);
            value = longint'(last_sample) + trend_dir * step;
         end
         if (value < band_lo) value = band_lo;
         if (value > band_hi) value = band_hi;
         last_sample = value[SampleWidth-1:0];
         window_samples.push_back(last_sample);
      end

      foreach (extreme_run[i]) window_samples.push_back(extreme_run[i]);

      // Rise/drop sweep: every rise followed by a drop adds a peak.
      for (int p = 0; p < SweepPairs; p++) begin
         value = longint'($urandom_range(0, 32'h3FFF_FFFF));
         step  = value + 1 + longint'($urandom_range(0, 32'h3FFF_FFFF));
         window_samples.push_back(step[SampleWidth-1:0]);
         if ($urandom_range(0, 19) == 0) begin
            window_samples.push_back(window_samples[$]);
         end
         window_samples.push_back(value[SampleWidth-1:0]);
      end
      total_samples = window_samples.size();

      while (samples_sent < total_samples || predicted_stats.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (predicted_stats.size() != 0) begin
         report_error($sformatf("%0d predicted results never arrived", predicted_stats.size()));
      end

      $display("Run covered %0d samples: opening cases, a widening random walk, field",
               samples_sent);
      $display("extremes and a rise/drop sweep; %0d results checked, %0d at the count ceiling.",
               results_checked, saturated_seen);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d errors found", error_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
